// ===== sv/wsd_pkg.sv =====
// ============================================================================
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ============================================================================
package wsd_pkg;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [31:0] MAX_LEN_RESET = 32'h0400_0000;

    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [7:0] PONG_HDR = 8'h80 | {4'h0, OP_PONG};

    typedef enum logic [2:0] {
        K_BYTE  = 3'd0,
        K_END   = 3'd1,
        K_PONG  = 3'd2,
        K_CLOSE = 3'd3,
        K_ABORT = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4,
        PH_DEAD = 3'd5
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        logic [3:0] code;
    } item_t;

    // up to two items pushed by the parser per accepted byte
    typedef struct packed {
        logic  v0;
        logic  v1;
        item_t e0;
        item_t e1;
    } push_t;

endpackage

// ===== sv/wsd_parser.sv =====
// ============================================================================
// wsd_parser
// Front end: parses frame headers, unmasks payload and classifies each
// received byte into zero, one or two result items.
// ============================================================================
module wsd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              acc,
    input  logic [7:0]        rx_byte,
    input  logic [31:0]       max_len,
    output wsd_pkg::push_t    push
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        final_reg, final_next;
    logic [3:0]  op_reg, op_next;
    logic        mpres_reg, mpres_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  pos_reg, pos_next;
    logic        nonempty_reg, nonempty_next;

    logic [63:0] len_cat;
    logic [31:0] key_cat;
    logic [6:0]  len7;
    logic        hd_fire;
    logic [63:0] hd_len;
    logic        hd_over;
    logic        hd_zero;
    logic        data_last;
    logic [7:0]  mb;
    logic [7:0]  ub;
    logic        is_data_op;

    // ---------------- datapath helpers ----------------
    always_comb begin
        len7       = rx_byte[6:0];
        len_cat    = {len_reg[55:0], rx_byte};
        key_cat    = {key_reg[23:0], rx_byte};
        is_data_op = (op_reg != OP_CLOSE) && (op_reg != OP_PING) && (op_reg != OP_PONG);
        hd_fire    = 1'b0;
        hd_len     = len_reg;
        unique case (phase_reg)
            PH_HDR1: begin
                hd_len  = {57'd0, len7};
                hd_fire = (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64) && !rx_byte[7];
            end
            PH_EXT: begin
                hd_len  = len_cat;
                hd_fire = (cnt_reg == 3'd0) && !mpres_reg;
            end
            PH_MASK: begin
                hd_fire = (cnt_reg == 3'd0);
            end
            default: ;
        endcase
        hd_over   = (hd_len[63:32] != 32'd0) || (hd_len[31:0] > max_len);
        hd_zero   = (hd_len == 64'd0);
        data_last = (remain_reg == 64'd1);
        case (pos_reg)
            2'd0:    mb = key_reg[31:24];
            2'd1:    mb = key_reg[23:16];
            2'd2:    mb = key_reg[15:8];
            default: mb = key_reg[7:0];
        endcase
        ub = rx_byte ^ mb;
    end

    // ---------------- next state ----------------
    always_comb begin
        phase_next    = phase_reg;
        final_next    = final_reg;
        op_next       = op_reg;
        mpres_next    = mpres_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        remain_next   = remain_reg;
        pos_next      = pos_reg;
        nonempty_next = nonempty_reg;
        if (acc) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    final_next = rx_byte[7];
                    op_next    = rx_byte[3:0];
                    key_next   = 32'd0;
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    mpres_next = rx_byte[7];
                    len_next   = 64'd0;
                    if (len7 == LEN7_EXT16) begin
                        cnt_next   = 3'd1;
                        phase_next = PH_EXT;
                    end else if (len7 == LEN7_EXT64) begin
                        cnt_next   = 3'd7;
                        phase_next = PH_EXT;
                    end else begin
                        len_next = {57'd0, len7};
                        if (rx_byte[7]) begin
                            cnt_next   = 3'd3;
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_EXT: begin
                    len_next = len_cat;
                    if (cnt_reg != 3'd0) begin
                        cnt_next = cnt_reg - 3'd1;
                    end else if (mpres_reg) begin
                        cnt_next   = 3'd3;
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK: begin
                    key_next = key_cat;
                    if (cnt_reg != 3'd0) begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                PH_DATA: begin
                    remain_next = remain_reg - 64'd1;
                    pos_next    = pos_reg + 2'd1;
                    if (data_last) begin
                        phase_next = (op_reg == OP_CLOSE) ? PH_DEAD : PH_HDR0;
                    end
                    if (is_data_op) begin
                        nonempty_next = !(data_last && final_reg);
                    end
                end
                default: ;
            endcase
            if (hd_fire) begin
                if (hd_over) begin
                    phase_next = PH_DEAD;
                end else if (!hd_zero) begin
                    phase_next  = PH_DATA;
                    remain_next = hd_len;
                    pos_next    = 2'd0;
                end else if (op_reg == OP_CLOSE) begin
                    phase_next = PH_DEAD;
                end else begin
                    phase_next = PH_HDR0;
                    if (is_data_op && final_reg) begin
                        nonempty_next = 1'b0;
                    end
                end
            end
        end
    end

    // ---------------- result items ----------------
    always_comb begin
        push         = '0;
        push.e0.code = op_reg;
        push.e1.code = op_reg;
        if (acc) begin
            if (hd_fire) begin
                if (hd_over) begin
                    push.v0      = 1'b1;
                    push.e0.kind = K_ABORT;
                end else if (op_reg == OP_PING) begin
                    push.v0      = 1'b1;
                    push.e0.kind = K_PONG;
                    push.e0.data = PONG_HDR;
                    push.v1      = 1'b1;
                    push.e1.kind = K_PONG;
                    push.e1.data = {1'b0, hd_len[6:0]};
                    push.e1.last = hd_zero;
                end else if (hd_zero && (op_reg == OP_CLOSE)) begin
                    push.v0      = 1'b1;
                    push.e0.kind = K_CLOSE;
                end else if (hd_zero && is_data_op && final_reg && nonempty_reg) begin
                    push.v0      = 1'b1;
                    push.e0.kind = K_END;
                end
            end else if (phase_reg == PH_DATA) begin
                if (op_reg == OP_PING) begin
                    push.v0      = 1'b1;
                    push.e0.kind = K_PONG;
                    push.e0.data = ub;
                    push.e0.last = data_last;
                end else if (op_reg == OP_CLOSE) begin
                    push.v0      = data_last;
                    push.e0.kind = K_CLOSE;
                end else if (op_reg != OP_PONG) begin
                    push.v0      = 1'b1;
                    push.e0.kind = K_BYTE;
                    push.e0.data = ub;
                    push.e0.last = data_last && final_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            final_reg    <= 1'b0;
            op_reg       <= 4'd0;
            mpres_reg    <= 1'b0;
            cnt_reg      <= 3'd0;
            len_reg      <= 64'd0;
            key_reg      <= 32'd0;
            remain_reg   <= 64'd0;
            pos_reg      <= 2'd0;
            nonempty_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            final_reg    <= final_next;
            op_reg       <= op_next;
            mpres_reg    <= mpres_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            remain_reg   <= remain_next;
            pos_reg      <= pos_next;
            nonempty_reg <= nonempty_next;
        end
    end

endmodule

// ===== sv/wsd_queue.sv =====
// ============================================================================
// wsd_queue
// Short queue between parser and output stage: two pushes, one pop a cycle.
// ============================================================================
module wsd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  wsd_pkg::push_t  push,
    input  logic            pop,
    output logic            room,
    output logic            q_valid,
    output wsd_pkg::item_t  q_item
);
    import wsd_pkg::*;

    item_t               mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_pop;

    // keep space for the two items a single byte may cause
    assign room    = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rd_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_next  = wr_reg + QPTR_W'(push.v0) + QPTR_W'(push.v1);
        rd_next  = rd_reg + QPTR_W'(do_pop);
        cnt_next = cnt_reg + QCNT_W'(push.v0) + QCNT_W'(push.v1) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_reg] <= push.e0;
        end
        if (push.v1) begin
            mem[wr_reg + QPTR_W'(1)] <= push.e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/wsd_out_stage.sv =====
// ============================================================================
// wsd_out_stage
// Back end: registered result channel, refilled from the queue each cycle
// it is empty or the downstream side takes an item.
// ============================================================================
module wsd_out_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  wsd_pkg::item_t  q_item,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tlast,
    output logic [2:0]      m_tuser
);
    import wsd_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  load;

    assign load       = !valid_reg || m_tready;
    assign pop        = load && q_valid;
    assign valid_next = load ? q_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= q_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, item_reg.code, item_reg.data};
    assign m_tlast  = item_reg.last;
    assign m_tuser  = item_reg.kind;

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// ============================================================================
// websocket_frame_deframer
// Received WebSocket byte stream in, message bytes, pong bytes and events out.
// ============================================================================
// Throughput: one received byte per cycle while the queue has room; a ping header
//   adds one extra result, drained by the output side at one result per cycle while
//   m_tready is high, through a 4-entry queue and a registered output stage.
// Reset: synchronous active-low aresetn returns the parser to header state,
//   empties the queue and loads max_frame_len with 64 MiB.
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,   // max_frame_len
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] out_byte, [11:8] frame_code, [15:12] zero
    output logic        m_tlast,     // out_last
    output logic [2:0]  m_tuser      // [2:0] out_kind
);
    import wsd_pkg::*;

    logic [31:0] max_len_reg;
    push_t       push;
    logic        room;
    logic        q_valid;
    item_t       q_item;
    logic        pop;
    logic        acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign s_tready = room;
    assign acc      = s_tvalid && room;

    wsd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .rx_byte (s_tdata),
        .max_len (max_len_reg),
        .push    (push)
    );

    wsd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .room    (room),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    wsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sv/wsd_checker.sv =====
// ============================================================================
// wsd_checker
// Port-level checks of the deframer result channel.
// ============================================================================
module wsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);
    import wsd_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= K_ABORT))
        else $error("undefined result kind");

    a_event_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_END || m_tuser == K_CLOSE || m_tuser == K_ABORT)
        |-> (m_tdata[7:0] == 8'd0) && !m_tlast)
        else $error("event item carries data or last");

    a_dead_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == K_CLOSE || m_tuser == K_ABORT)
        |=> !m_tvalid)
        else $error("result item after close or abort");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
